@@ rtl/b64e_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the character mapping shared by the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CHAR_W = 7;
  localparam int SEXTET_W = 6;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;
  localparam logic [CHAR_W-1:0] PLUS_CHAR = 7'd43;
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'd47;
  localparam logic [CHAR_W-1:0] UPPER_A = 7'd65;
  localparam logic [CHAR_W-1:0] LOWER_A = 7'd71;
  localparam logic [CHAR_W-1:0] DIGIT_0 = 7'd4;

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD = 2'd2;

  // One group of up to four characters produced by one input byte.
  typedef struct packed {
    logic [3:0][CHAR_W-1:0] chars;
    logic [1:0]             last_idx;
    logic                   last;
  } b64e_job_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] c;
    c = {1'b0, v};
    if (v < 6'd26) begin
      sextet_char = c + UPPER_A;
    end else if (v < 6'd52) begin
      sextet_char = c + LOWER_A;
    end else if (v < 6'd62) begin
      sextet_char = c - DIGIT_0;
    end else if (v == 6'd62) begin
      sextet_char = PLUS_CHAR;
    end else begin
      sextet_char = SLASH_CHAR;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/base64_stream_encoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming Base64 encoder with '=' padding, one byte in and one character
// out per beat.
// ----------------------------------------------------------------------------
// A byte is taken whenever the group queue has room; each byte turns into
// one to four characters, which leave through a registered output at one
// character per cycle while pop is held. The first character of a byte
// passes through the group queue, the job register and the output register.
// Sustained throughput is set by the one-character output port: four
// characters per three bytes in a message, plus padding after its last byte.
module base64_stream_encoder_top #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_final_byte,
  input  wire logic       push,
  output logic            full,
  output logic [6:0]      out_char,
  output logic            out_end_of_text,
  output logic            empty,
  input  wire logic       pop
);

  b64e_pkg::b64e_job_t wr_job;
  b64e_pkg::b64e_job_t rd_job;
  logic q_full;
  logic q_push;
  logic rd_en;
  logic rd_valid;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .push       (push),
    .full       (full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (wr_job)
  );

  b64e_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_job   (wr_job),
    .q_full   (q_full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_job   (rd_job)
  );

  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rd_valid        (rd_valid),
    .rd_job          (rd_job),
    .rd_en           (rd_en),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text),
    .empty           (empty),
    .pop             (pop)
  );

endmodule
`default_nettype wire

@@ rtl/b64e_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the group position and builds each byte's
// group of output characters for the queue.
// ----------------------------------------------------------------------------
module b64e_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         data_byte,
  input  wire logic               final_byte,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               q_full,
  output logic                    q_push,
  output b64e_pkg::b64e_job_t     q_job
);

  logic [1:0] pos_r;
  logic [1:0] pos_nxt;
  logic [3:0] left_r;
  logic [3:0] left_nxt;
  logic       accept;

  assign full = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    q_job.chars = {4{b64e_pkg::PAD_CHAR}};
    q_job.last_idx = 2'd0;
    q_job.last = final_byte;
    pos_nxt = b64e_pkg::POS_FIRST;
    left_nxt = 4'd0;
    unique case (pos_r)
      b64e_pkg::POS_SECOND: begin
        q_job.chars[0] = b64e_pkg::sextet_char({left_r[1:0], data_byte[7:4]});
        if (final_byte) begin
          q_job.chars[1] = b64e_pkg::sextet_char({data_byte[3:0], 2'b00});
          q_job.last_idx = 2'd2;
        end else begin
          pos_nxt = b64e_pkg::POS_THIRD;
          left_nxt = data_byte[3:0];
        end
      end
      b64e_pkg::POS_THIRD: begin
        q_job.chars[0] = b64e_pkg::sextet_char({left_r, data_byte[7:6]});
        q_job.chars[1] = b64e_pkg::sextet_char(data_byte[5:0]);
        q_job.last_idx = 2'd1;
      end
      default: begin
        q_job.chars[0] = b64e_pkg::sextet_char(data_byte[7:2]);
        if (final_byte) begin
          q_job.chars[1] = b64e_pkg::sextet_char({data_byte[1:0], 4'b0000});
          q_job.last_idx = 2'd3;
        end else begin
          pos_nxt = b64e_pkg::POS_SECOND;
          left_nxt = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= b64e_pkg::POS_FIRST;
      left_r <= 4'd0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      left_r <= left_nxt;
    end
  end

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && final_byte) |=> (pos_r == b64e_pkg::POS_FIRST && left_r == 4'd0))
    else $error("group did not restart after the last byte");

  a_pos_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == b64e_pkg::POS_FIRST && !final_byte) |=>
      (pos_r == b64e_pkg::POS_SECOND && left_r[3:2] == 2'b00))
    else $error("first byte of a group left a wrong state");

endmodule
`default_nettype wire

@@ rtl/b64e_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of character groups between the front
// and back parts.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  b64e_pkg::b64e_job_t     wr_job,
  output logic                    q_full,
  input  wire logic               rd_en,
  output logic                    rd_valid,
  output b64e_pkg::b64e_job_t     rd_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64e_pkg::b64e_job_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_wr;
  logic            do_rd;

  assign q_full = (count_r == CntW'(Depth));
  assign rd_valid = (count_r != '0);
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && rd_valid;
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("queue count exceeds its depth");

endmodule
`default_nettype wire

@@ rtl/b64e_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Takes character groups from the queue and sends them out one character
// per beat through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_valid,
  input  b64e_pkg::b64e_job_t     rd_job,
  output logic                    rd_en,
  output logic [6:0]              out_char,
  output logic                    out_end_of_text,
  output logic                    empty,
  input  wire logic               pop
);

  b64e_pkg::b64e_job_t job_r;
  logic       job_valid_r;
  logic [1:0] idx_r;
  logic [6:0] char_r;
  logic       eot_r;
  logic       out_valid_r;
  logic       advance;
  logic       job_done;

  assign advance = job_valid_r && (!out_valid_r || pop);
  assign job_done = advance && (idx_r == job_r.last_idx);
  assign rd_en = rd_valid && (!job_valid_r || job_done);

  assign out_char = char_r;
  assign out_end_of_text = eot_r;
  assign empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      job_r <= rd_job;
    end
    if (advance) begin
      char_r <= job_r.chars[idx_r];
      eot_r <= job_done && job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (rd_en) begin
        job_valid_r <= 1'b1;
        idx_r <= 2'd0;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
      end else if (advance) begin
        idx_r <= idx_r + 1'b1;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (idx_r <= job_r.last_idx))
    else $error("character index ran past the end of its group");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming Base64 encoder. A byte driver and a
// character monitor run as clocked processes. Every accepted byte is encoded
// by a local model of the group state, and the characters it must produce
// are queued. Each character popped from the encoder is compared in order
// with that queue. A directed set of short messages is followed by random
// messages, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_BYTES = 270;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int CALM_FROM = 200;
  localparam int CALM_TO = 450;
  localparam int N_DIRECTED = 25;
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Bit 8 flags the last byte of a message.
  localparam logic [8:0] DIRECTED_BYTES [N_DIRECTED] = '{
    9'h100,
    9'h1FF,
    9'h0FF, 9'h1FF,
    9'h000, 9'h000, 9'h100,
    9'h0FB, 9'h0EF, 9'h1BE,
    9'h0FF, 9'h0FF, 9'h1FF,
    9'h04D, 9'h061, 9'h16E,
    9'h001, 9'h002, 9'h003, 9'h104,
    9'h080, 9'h07F, 9'h0AA, 9'h055, 9'h10F
  };

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } msg_byte_t;

  typedef struct packed {
    logic [b64e_pkg::CHAR_W-1:0] code;
    logic                        eot;
  } text_char_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic [7:0]                  in_data_byte = '0;
  logic                        in_final_byte = 1'b0;
  logic                        push = 1'b0;
  logic                        pop = 1'b0;
  logic                        full;
  logic                        empty;
  logic [b64e_pkg::CHAR_W-1:0] out_char;
  logic                        out_end_of_text;

  msg_byte_t  message_bytes[$];
  text_char_t encoded_text[$];
  logic [1:0] group_pos = b64e_pkg::POS_FIRST;
  logic [3:0] carry_bits = '0;
  logic       byte_taken = 1'b0;
  int         cycle_count = 0;
  int         error_count = 0;

  base64_stream_encoder_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .push            (push),
    .full            (full),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text),
    .empty           (empty),
    .pop             (pop)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [b64e_pkg::CHAR_W-1:0] b64_symbol(input logic [5:0] v);
    int idx;
    idx = 63 - int'(v);
    b64_symbol = B64_ALPHABET[8*idx +: b64e_pkg::CHAR_W];
  endfunction

  function automatic bit idle_now();
    bit calm;
    calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
    idle_now = !calm && ($urandom_range(99) < 20);
  endfunction

  task automatic add_char(input logic [b64e_pkg::CHAR_W-1:0] code, input logic eot);
    text_char_t c;
    c.code = code;
    c.eot = eot;
    encoded_text = {encoded_text, c};
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (group_pos)
      b64e_pkg::POS_SECOND: begin
        add_char(b64_symbol({carry_bits[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          add_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
          add_char(b64e_pkg::PAD_CHAR, 1'b1);
          group_pos = b64e_pkg::POS_FIRST;
          carry_bits = '0;
        end else begin
          group_pos = b64e_pkg::POS_THIRD;
          carry_bits = b[3:0];
        end
      end
      b64e_pkg::POS_THIRD: begin
        add_char(b64_symbol({carry_bits, b[7:6]}), 1'b0);
        add_char(b64_symbol(b[5:0]), fin);
        group_pos = b64e_pkg::POS_FIRST;
        carry_bits = '0;
      end
      default: begin
        add_char(b64_symbol(b[7:2]), 1'b0);
        if (fin) begin
          add_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
          add_char(b64e_pkg::PAD_CHAR, 1'b0);
          add_char(b64e_pkg::PAD_CHAR, 1'b1);
          group_pos = b64e_pkg::POS_FIRST;
          carry_bits = '0;
        end else begin
          group_pos = b64e_pkg::POS_SECOND;
          carry_bits = {2'b00, b[1:0]};
        end
      end
    endcase
  endtask

  always @(negedge clk) begin : byte_driver
    if (byte_taken) begin
      void'(message_bytes.pop_front());
    end
    if (rst_n && message_bytes.size() != 0 && !idle_now()) begin
      push <= 1'b1;
      in_data_byte <= message_bytes[0].data;
      in_final_byte <= message_bytes[0].fin;
    end else begin
      push <= 1'b0;
    end
    pop <= rst_n && !idle_now();
  end

  always @(posedge clk) begin : char_monitor
    text_char_t want;
    cycle_count <= cycle_count + 1;
    byte_taken <= rst_n && push && !full;
    if (rst_n && push && !full) begin
      encode_byte(in_data_byte, in_final_byte);
    end
    if (rst_n && pop && !empty) begin
      if (encoded_text.size() == 0) begin
        $error("out_char: no character expected, actual %0d", out_char);
        error_count++;
      end else begin
        want = encoded_text.pop_front();
        if (out_char !== want.code) begin
          $error("out_char: expected %0d, actual %0d", want.code, out_char);
          error_count++;
        end
        if (out_end_of_text !== want.eot) begin
          $error("out_end_of_text: expected %0d, actual %0d", want.eot, out_end_of_text);
          error_count++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** base64_stream_encoder_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    msg_byte_t mb;
    int        n_random;
    int        len;
    foreach (DIRECTED_BYTES[k]) begin
      mb.data = DIRECTED_BYTES[k][7:0];
      mb.fin = DIRECTED_BYTES[k][8];
      message_bytes = {message_bytes, mb};
    end
    n_random = 0;
    while (n_random < RANDOM_BYTES) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          mb.data = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
          mb.data = 8'($urandom());
        end
        mb.fin = (i == len - 1);
        message_bytes = {message_bytes, mb};
        n_random++;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (message_bytes.size() != 0 || encoded_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && encoded_text.size() == 0) begin
      $display("** base64_stream_encoder_top: PASSED **");
    end else begin
      $display("** base64_stream_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_top.sv
sim/tb_top.sv
